// ===== rtl/lz4s_pkg.sv =====
// Shared types and constants for the LZ4s-to-sequence parser.
// No dependencies; used by every file under rtl/.

package lz4s_pkg;

  // Parameter defaults
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 131072;

  // Fixed field widths of the ports
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIT_W   = 18;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned MLEN_W  = 18;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BIAS_W  = 2;
  localparam int unsigned NIB_W   = 4;

  localparam logic [BIAS_W-1:0] BIAS_RESET = 2'd2;
  localparam logic [BYTE_W-1:0] EXT_BYTE   = 8'hFF;
  localparam logic [NIB_W-1:0]  NIBBLE_MAX = 4'hF;

  // Result queue sizing: one byte can push two results
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_EXT   = 3'd1,
    PH_LIT_SKIP  = 3'd2,
    PH_OFF_LO    = 3'd3,
    PH_OFF_HI    = 3'd4,
    PH_MATCH_EXT = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEQ   = 2'd0,
    KIND_DELIM = 2'd1,
    KIND_TRUNC = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LIT_W-1:0]  lit;
    logic [OFF_W-1:0]  off;
    logic [MLEN_W-1:0] mlen;
    kind_t             kind;
    logic              last;
  } result_t;

endpackage

// ===== rtl/lz4s_seq_parse.sv =====
// Byte-at-a-time LZ4s token parser: parser state registers and the next-state
// and result logic for one byte. Depends on lz4s_pkg.

module lz4s_seq_parse #(
  parameter int unsigned MAX_BLOCK_BYTES = lz4s_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [lz4s_pkg::BYTE_W-1:0] data_byte,
  input  logic                        block_end,
  input  logic [lz4s_pkg::BIAS_W-1:0] bias,
  output logic [1:0]                  res_vld,
  output lz4s_pkg::result_t           res0,
  output lz4s_pkg::result_t           res1
);

  localparam int unsigned LEN_W = $clog2(MAX_BLOCK_BYTES);
  localparam int unsigned SUM_W = LEN_W + 1;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_BLOCK_BYTES - 1);

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, LEN_CAP}) ? LEN_CAP : s[LEN_W-1:0];
  endfunction

  lz4s_pkg::phase_t                phase, phase_next;
  logic [lz4s_pkg::NIB_W-1:0]      nib, nib_next;
  logic [LEN_W-1:0]                run, run_next;
  logic [LEN_W-1:0]                skip, skip_next;
  logic [LEN_W-1:0]                pend, pend_next;
  logic [lz4s_pkg::OFF_W-1:0]      off, off_next;
  logic [LEN_W-1:0]                macc, macc_next;

  logic [LEN_W-1:0]                byte_ext;
  logic                            lit_done, match_done, lit_end, seq_v;
  logic [SUM_W-1:0]                lit_sum;
  logic [SUM_W-1:0]                tail_lit;
  logic [lz4s_pkg::OFF_W-1:0]      seq_off;
  logic [LEN_W-1:0]                seq_macc;

  assign byte_ext = LEN_W'(data_byte);

  // Next state for one byte
  always_comb begin
    phase_next = phase;
    nib_next   = nib;
    run_next   = run;
    skip_next  = skip;
    pend_next  = pend;
    off_next   = off;
    macc_next  = macc;
    lit_done   = 1'b0;
    match_done = 1'b0;
    lit_end    = 1'b0;
    seq_v      = 1'b0;

    unique case (phase)
      lz4s_pkg::PH_LIT_EXT: begin
        run_next = sat_add(run, byte_ext);
        lit_done = (data_byte != lz4s_pkg::EXT_BYTE);
      end
      lz4s_pkg::PH_LIT_SKIP: begin
        if (skip != '0) begin
          skip_next = skip - LEN_W'(1);
        end
        lit_done = (skip_next == '0);
      end
      lz4s_pkg::PH_OFF_LO: begin
        off_next   = lz4s_pkg::OFF_W'(data_byte);
        phase_next = lz4s_pkg::PH_OFF_HI;
      end
      lz4s_pkg::PH_OFF_HI: begin
        off_next = {data_byte, off[7:0]};
        if (nib == lz4s_pkg::NIBBLE_MAX) begin
          macc_next  = LEN_W'(lz4s_pkg::NIBBLE_MAX);
          phase_next = lz4s_pkg::PH_MATCH_EXT;
        end else begin
          macc_next  = LEN_W'(nib);
          match_done = 1'b1;
        end
      end
      lz4s_pkg::PH_MATCH_EXT: begin
        macc_next  = sat_add(macc, byte_ext);
        match_done = (data_byte != lz4s_pkg::EXT_BYTE);
      end
      default: begin
        // token byte
        nib_next  = data_byte[3:0];
        run_next  = LEN_W'(data_byte[7:4]);
        skip_next = '0;
        if (data_byte[7:4] == lz4s_pkg::NIBBLE_MAX) begin
          phase_next = lz4s_pkg::PH_LIT_EXT;
        end else if (data_byte[7:4] == '0) begin
          lit_done = 1'b1;
        end else begin
          skip_next  = LEN_W'(data_byte[7:4]);
          phase_next = lz4s_pkg::PH_LIT_SKIP;
        end
      end
    endcase

    lit_sum  = {1'b0, pend} + {1'b0, run_next};
    seq_off  = off_next;
    seq_macc = macc_next;

    if (lit_done) begin
      if (phase == lz4s_pkg::PH_LIT_EXT && run_next != '0) begin
        skip_next  = run_next;
        phase_next = lz4s_pkg::PH_LIT_SKIP;
      end else if (block_end) begin
        lit_end = 1'b1;
      end else begin
        skip_next  = '0;
        phase_next = lz4s_pkg::PH_OFF_LO;
      end
    end

    if (match_done) begin
      if (macc_next != '0) begin
        seq_v     = 1'b1;
        pend_next = '0;
      end else begin
        pend_next = sat_add(pend, run_next);
      end
      run_next   = '0;
      skip_next  = '0;
      phase_next = lz4s_pkg::PH_TOKEN;
    end

    if (lit_end) begin
      tail_lit = lit_sum;
    end else if (match_done) begin
      tail_lit = SUM_W'(pend_next);
    end else begin
      tail_lit = '0;
    end

    // block end: drop all parser state, next byte opens a new block
    if (block_end) begin
      phase_next = lz4s_pkg::PH_TOKEN;
      nib_next   = '0;
      run_next   = '0;
      skip_next  = '0;
      pend_next  = '0;
      off_next   = '0;
      macc_next  = '0;
    end
  end

  // Result construction: optional sequence first, then delimiter or error
  always_comb begin
    lz4s_pkg::result_t seq_r, tail_r;
    seq_r.lit  = lz4s_pkg::LIT_W'(lit_sum);
    seq_r.off  = seq_off;
    seq_r.mlen = lz4s_pkg::MLEN_W'({1'b0, seq_macc} + SUM_W'(bias));
    seq_r.kind = lz4s_pkg::KIND_SEQ;
    seq_r.last = !block_end;

    tail_r.lit  = lz4s_pkg::LIT_W'(tail_lit);
    tail_r.off  = '0;
    tail_r.mlen = '0;
    tail_r.kind = (lit_end || match_done) ? lz4s_pkg::KIND_DELIM : lz4s_pkg::KIND_TRUNC;
    tail_r.last = 1'b1;

    if (seq_v) begin
      res0    = seq_r;
      res1    = tail_r;
      res_vld = {block_end, 1'b1};
    end else begin
      res0    = tail_r;
      res1    = tail_r;
      res_vld = {1'b0, block_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lz4s_pkg::PH_TOKEN;
      nib   <= '0;
      run   <= '0;
      skip  <= '0;
      pend  <= '0;
      off   <= '0;
      macc  <= '0;
    end else if (step) begin
      phase <= phase_next;
      nib   <= nib_next;
      run   <= run_next;
      skip  <= skip_next;
      pend  <= pend_next;
      off   <= off_next;
      macc  <= macc_next;
    end
  end

endmodule

// ===== rtl/lz4s_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and releases one.
// Depends on lz4s_pkg.

module lz4s_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push,
  input  lz4s_pkg::result_t wdata0,
  input  lz4s_pkg::result_t wdata1,
  input  logic              pop,
  output logic              room2,
  output logic              rvalid,
  output lz4s_pkg::result_t rdata
);

  lz4s_pkg::result_t               mem [lz4s_pkg::RES_DEPTH];
  logic [lz4s_pkg::RES_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [lz4s_pkg::RES_CNT_W-1:0]  count, count_next;
  logic [lz4s_pkg::RES_PTR_W-1:0]  wr_ptr1;
  logic [lz4s_pkg::RES_CNT_W-1:0]  n_push;
  logic                            do_pop;

  assign rvalid  = (count != '0);
  assign room2   = (count <= lz4s_pkg::RES_CNT_W'(lz4s_pkg::RES_DEPTH - 2));
  assign rdata   = mem[rd_ptr];
  assign do_pop  = pop && rvalid;
  assign wr_ptr1 = wr_ptr + lz4s_pkg::RES_PTR_W'(1);
  assign n_push  = lz4s_pkg::RES_CNT_W'(push[0]) + lz4s_pkg::RES_CNT_W'(push[1]);
  assign count_next = count + n_push - lz4s_pkg::RES_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (push[0]) begin
      mem[wr_ptr] <= wdata0;
    end
    if (push[1]) begin
      mem[wr_ptr1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lz4s_pkg::RES_PTR_W'(n_push);
      rd_ptr <= rd_ptr + lz4s_pkg::RES_PTR_W'(do_pop);
      count  <= count_next;
    end
  end

endmodule

// ===== rtl/lz4s_to_sequence_parser.sv =====
// Top level of the LZ4s block to sequence parser.
// Depends on lz4s_pkg, lz4s_seq_parse and lz4s_result_fifo.

// The block takes one byte of an LZ4s block body per transfer on the s_ side
// (s_tlast marks the block's final byte) and emits sequences on the m_ side:
// literal length, match offset and biased match length, followed at block end
// by a literal-only delimiter, or by a truncation error if the block stops in
// the middle of a field. A byte is parsed in the cycle it is accepted, so a
// new byte is taken every cycle; a byte yields zero, one or two results, and
// results leave one per cycle through a four-entry result queue. s_tready is
// high while at least two queue slots are free, so the input runs at one byte
// per cycle except when a backlog of results builds up on a stalled m_ side.
// m_tlast marks the last result caused by one input byte. The match length
// bias is written through the cfg_ channel, always ready; write it only while
// the block is idle. Reset is synchronous and active high.

module lz4s_to_sequence_parser #(
  parameter int unsigned MAX_BLOCK_BYTES = lz4s_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // block_end
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [17:0] literal_length, [33:18] match_offset,
                                 // [51:34] match_length, [55:52] zero
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast,   // run_last
  // match length bias register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic [lz4s_pkg::BIAS_W-1:0] bias;
  logic                        in_xfer;
  logic [1:0]                  res_vld;
  lz4s_pkg::result_t           res0, res1, head;
  logic                        room2;

  // Bias register: always ready, write on every cfg transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= lz4s_pkg::BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bias <= cfg_data;
    end
  end

  // Hold off input unless a two-result byte can still be queued
  assign s_tready = room2;
  assign in_xfer  = s_tvalid && s_tready;

  lz4s_seq_parse #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (in_xfer),
    .data_byte (s_tdata),
    .block_end (s_tlast),
    .bias      (bias),
    .res_vld   (res_vld),
    .res0      (res0),
    .res1      (res1)
  );

  lz4s_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (res_vld & {2{in_xfer}}),
    .wdata0 (res0),
    .wdata1 (res1),
    .pop    (m_tready),
    .room2  (room2),
    .rvalid (m_tvalid),
    .rdata  (head)
  );

  // Pack the head result onto the output stream
  assign m_tdata = {4'b0000, head.mlen, head.off, head.lit};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

// ===== rtl/lz4s_checker.sv =====
// Port-level checks for lz4s_to_sequence_parser, attached by bind.
// Depends on lz4s_pkg.

module lz4s_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Delimiters and errors always close the results of their byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != lz4s_pkg::KIND_SEQ |-> m_tlast)
    else $error("delimiter or error result without tlast");

  // Delimiters and errors carry no match
  a_end_no_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != lz4s_pkg::KIND_SEQ |-> m_tdata[51:18] == '0)
    else $error("delimiter or error result with match fields");

  // A truncation error reports no literals
  a_trunc_no_lit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lz4s_pkg::KIND_TRUNC |-> m_tdata[17:0] == '0)
    else $error("truncation result with literal length");

  // A match sequence always has a nonzero match length
  a_seq_has_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lz4s_pkg::KIND_SEQ |-> m_tdata[51:34] != '0)
    else $error("sequence with zero match length");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind lz4s_to_sequence_parser lz4s_checker u_lz4s_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

// ===== bench/testbench.sv =====
// Self-checking bench for lz4s_to_sequence_parser: drives LZ4s block bytes,
// predicts every sequence, delimiter and truncation result, and checks them.
// Depends on lz4s_pkg and the RTL of lz4s_to_sequence_parser.

module testbench;

  localparam int unsigned MAX_BLOCK = lz4s_pkg::MAX_BLOCK_BYTES_DEF;
  localparam int unsigned LEN_CAP   = MAX_BLOCK - 1;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;

  lz4s_to_sequence_parser #(
    .MAX_BLOCK_BYTES(MAX_BLOCK)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(8 * 3_000_000);
    $display("status: fail");
    $finish;
  end

  body_byte_t         byte_q[$];        // bytes waiting to be offered
  body_byte_t         block_buf[$];     // block under construction
  lz4s_pkg::result_t  predicted_seqs[$];

  int unsigned error_count    = 0;
  int unsigned byte_transfers = 0;
  int unsigned result_count   = 0;
  int unsigned block_count    = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  bit          long_gaps      = 1'b1;

  // ---------------------------------------------------------------------------
  // Parser predictor: mirrors the block's parse state, one byte at a time.
  // ---------------------------------------------------------------------------
  lz4s_pkg::phase_t p_phase = lz4s_pkg::PH_TOKEN;
  logic [3:0]  p_mnib  = '0;
  logic [16:0] p_run   = '0;
  logic [16:0] p_skip  = '0;
  logic [16:0] p_pend  = '0;
  logic [15:0] p_off   = '0;
  logic [16:0] p_macc  = '0;
  logic [1:0]  p_bias  = lz4s_pkg::BIAS_RESET;

  // Saturate run totals at the block length cap; never wrap.
  function automatic logic [16:0] cap_sum(input logic [16:0] a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > LEN_CAP) ? 17'(LEN_CAP) : 17'(s);
  endfunction

  function automatic lz4s_pkg::result_t make_result(input logic [17:0] lit,
                                                    input logic [15:0] off,
                                                    input logic [17:0] mlen,
                                                    input lz4s_pkg::kind_t kind);
    lz4s_pkg::result_t r;
    r.lit  = lit;
    r.off  = off;
    r.mlen = mlen;
    r.kind = kind;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic parse_lz4s_byte(input logic [7:0] b, input logic last);
    lz4s_pkg::result_t outs [2];
    int      n = 0;
    bit      lit_done = 1'b0;
    bit      match_done = 1'b0;
    bit      boundary = 1'b0;
    bit      closed = 1'b0;
    case (p_phase)
      lz4s_pkg::PH_LIT_EXT: begin
        p_run = cap_sum(p_run, b);
        if (b != lz4s_pkg::EXT_BYTE) lit_done = 1'b1;
      end
      lz4s_pkg::PH_LIT_SKIP: begin
        if (p_skip != 0) p_skip = p_skip - 17'd1;
        if (p_skip == 0) lit_done = 1'b1;
      end
      lz4s_pkg::PH_OFF_LO: begin
        p_off   = {8'h00, b};
        p_phase = lz4s_pkg::PH_OFF_HI;
      end
      lz4s_pkg::PH_OFF_HI: begin
        p_off[15:8] = b;
        if (p_mnib == lz4s_pkg::NIBBLE_MAX) begin
          p_macc  = 17'(lz4s_pkg::NIBBLE_MAX);
          p_phase = lz4s_pkg::PH_MATCH_EXT;
        end else begin
          p_macc     = 17'(p_mnib);
          match_done = 1'b1;
        end
      end
      lz4s_pkg::PH_MATCH_EXT: begin
        p_macc = cap_sum(p_macc, b);
        if (b != lz4s_pkg::EXT_BYTE) match_done = 1'b1;
      end
      default: begin
        // token: high nibble literals, low nibble match
        p_mnib = b[3:0];
        p_run  = 17'(b[7:4]);
        p_skip = '0;
        if (b[7:4] == lz4s_pkg::NIBBLE_MAX) begin
          p_phase = lz4s_pkg::PH_LIT_EXT;
        end else if (b[7:4] == 4'd0) begin
          lit_done = 1'b1;
        end else begin
          p_skip  = 17'(b[7:4]);
          p_phase = lz4s_pkg::PH_LIT_SKIP;
        end
      end
    endcase

    if (lit_done) begin
      if (p_phase == lz4s_pkg::PH_LIT_EXT && p_run != 0) begin
        p_skip  = p_run;
        p_phase = lz4s_pkg::PH_LIT_SKIP;
      end else if (last) begin
        // literals end the block: one delimiter with everything pending
        outs[n] = make_result(18'(p_pend) + 18'(p_run), '0, '0, lz4s_pkg::KIND_DELIM);
        n++;
        closed = 1'b1;
      end else begin
        p_skip  = '0;
        p_phase = lz4s_pkg::PH_OFF_LO;
      end
    end

    if (!closed) begin
      if (match_done) begin
        if (p_macc != 0) begin
          outs[n] = make_result(18'(p_pend) + 18'(p_run), p_off,
                                18'(p_macc) + 18'(p_bias), lz4s_pkg::KIND_SEQ);
          n++;
          p_pend = '0;
        end else begin
          // zero match: carry the literals into the next sequence
          p_pend = cap_sum(p_pend, p_run);
        end
        p_run    = '0;
        p_skip   = '0;
        p_phase  = lz4s_pkg::PH_TOKEN;
        boundary = 1'b1;
      end
      if (last) begin
        outs[n] = boundary ? make_result(18'(p_pend), '0, '0, lz4s_pkg::KIND_DELIM)
                           : make_result('0, '0, '0, lz4s_pkg::KIND_TRUNC);
        n++;
      end
    end

    if (last) begin
      p_phase = lz4s_pkg::PH_TOKEN;
      p_mnib  = '0;
      p_run   = '0;
      p_skip  = '0;
      p_pend  = '0;
      p_off   = '0;
      p_macc  = '0;
    end

    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      predicted_seqs = {predicted_seqs, outs[i]};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("mismatch %0d: %s", error_count + 1, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                result_count, name, got, want));
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned draw_gap(input bit long_ok);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95 || !long_ok) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes, predict each accepted transfer.
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;

  always @(posedge clk) begin : drive_bytes
    body_byte_t nxt;
    if (rst) begin
      s_tvalid  <= 1'b0;
      send_gap  <= 0;
      send_calm <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_lz4s_byte(s_tdata, s_tlast);
        byte_transfers++;
      end
      // hold the byte while it is stalled, else move on
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
            send_gap  <= 0;
          end else begin
            send_gap <= draw_gap(long_gaps);
            if ($urandom_range(99) == 0) send_calm <= $urandom_range(200, 40);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned recv_gap  = 0;
  int unsigned recv_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      recv_gap  <= 0;
      recv_calm <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (recv_calm != 0) begin
        recv_calm <= recv_calm - 1;
      end else begin
        recv_gap <= draw_gap(1'b1);
        if ($urandom_range(99) == 0) recv_calm <= $urandom_range(200, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    lz4s_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_seqs.size() == 0) begin
        report_mismatch($sformatf("unexpected result lit %0d off %0d mlen %0d kind %0d",
                                  m_tdata[17:0], m_tdata[33:18], m_tdata[51:34], m_tuser));
      end else begin
        want = predicted_seqs.pop_front();
        check_field("literal_length", m_tdata[17:0], want.lit);
        check_field("match_offset", m_tdata[33:18], want.off);
        check_field("match_length", m_tdata[51:34], want.mlen);
        check_field("result_kind", m_tuser, want.kind);
        check_field("run_last", m_tlast, want.last);
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Block builders
  // ---------------------------------------------------------------------------
  function automatic void put_byte(input logic [7:0] b, input logic last);
    body_byte_t e;
    e.data = b;
    e.last = last;
    byte_q = {byte_q, e};
  endfunction

  function automatic void buf_byte(input logic [7:0] b);
    body_byte_t e;
    e.data = b;
    e.last = 1'b0;
    block_buf = {block_buf, e};
  endfunction

  // Emit the extension bytes of a length above the nibble.
  function automatic void buf_len_ext(input int unsigned rem);
    while (rem >= 255) begin
      buf_byte(lz4s_pkg::EXT_BYTE);
      rem -= 255;
    end
    buf_byte(8'(rem));
  endfunction

  function automatic void buf_literals(input int unsigned lit);
    // the block skips at most the capped run length
    int unsigned cnt;
    cnt = (lit > LEN_CAP) ? LEN_CAP : lit;
    repeat (cnt) buf_byte(8'($urandom));
  endfunction

  function automatic void buf_sequence(input int unsigned lit, input int unsigned mraw,
                                       input logic [15:0] off);
    logic [3:0] ln;
    logic [3:0] mn;
    ln = (lit >= 15) ? lz4s_pkg::NIBBLE_MAX : 4'(lit);
    mn = (mraw >= 15) ? lz4s_pkg::NIBBLE_MAX : 4'(mraw);
    buf_byte({ln, mn});
    if (lit >= 15) buf_len_ext(lit - 15);
    buf_literals(lit);
    buf_byte(off[7:0]);
    buf_byte(off[15:8]);
    if (mraw >= 15) buf_len_ext(mraw - 15);
  endfunction

  // Literal-only closing token; its match nibble is never read.
  function automatic void buf_tail(input int unsigned lit);
    logic [3:0] ln;
    ln = (lit >= 15) ? lz4s_pkg::NIBBLE_MAX : 4'(lit);
    buf_byte({ln, 4'($urandom)});
    if (lit >= 15) buf_len_ext(lit - 15);
    buf_literals(lit);
  endfunction

  // Flag the last kept byte and queue the block.
  function automatic void ship_block(input int unsigned keep);
    for (int unsigned i = 0; i < keep; i++) begin
      if (i == keep - 1) block_buf[i].last = 1'b1;
      byte_q = {byte_q, block_buf[i]};
    end
    block_buf.delete();
    block_count++;
  endfunction

  function automatic int unsigned pick_literals();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(6, 1);
    if (r < 98) return $urandom_range(40, 15);
    return $urandom_range(400, 255);
  endfunction

  function automatic int unsigned pick_match();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 80) return $urandom_range(14, 1);
    if (r < 95) return $urandom_range(30, 15);
    return $urandom_range(600, 270);
  endfunction

  // One random block: mostly well formed, some cut short, some noise.
  function automatic int unsigned random_block();
    int unsigned style;
    int unsigned len;
    style = $urandom_range(99);
    if (style < 15) begin
      repeat ($urandom_range(12, 1)) buf_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(4, 0))
        buf_sequence(pick_literals(), pick_match(), 16'($urandom));
      if (style < 55 || block_buf.size() == 0) buf_tail(pick_literals());
    end
    len = block_buf.size();
    if (style >= 80) len = $urandom_range(len, 1);
    ship_block(len);
    return len;
  endfunction

  function automatic void random_phase(input int unsigned target);
    int unsigned total;
    total = 0;
    while (total < target) total += random_block();
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing helpers used by the stimulus process
  // ---------------------------------------------------------------------------
  task automatic write_bias(input logic [1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    p_bias = value;
  endtask

  // Wait until every byte is taken and every result is back, then let the
  // pipeline settle before touching the register.
  task automatic drain_results();
    int unsigned spin;
    spin = 0;
    while (byte_q.size() != 0 || s_tvalid) @(posedge clk);
    while (predicted_seqs.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    while (predicted_seqs.size() != 0) begin
      report_mismatch("expected result never arrived");
      void'(predicted_seqs.pop_front());
    end
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes at the reset bias.
    put_byte(8'h00, 1'b1);              // empty literal token closes the block
    put_byte(8'h10, 1'b0);              // one literal, zero match ending the block
    put_byte(8'hAA, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    put_byte(8'hF0, 1'b1);              // cut inside the literal extension
    put_byte(8'h2E, 1'b0);              // two literals, match nibble 14
    put_byte(8'h55, 1'b0);
    put_byte(8'hAA, 1'b0);
    put_byte(8'h34, 1'b0);
    put_byte(8'h12, 1'b0);
    put_byte(8'h0F, 1'b0);              // extended match at the largest offset
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);              // match ends on the last byte
    put_byte(8'h01, 1'b0);              // cut after the offset low byte
    put_byte(8'h80, 1'b1);
    put_byte(8'h12, 1'b0);              // literals end on the last byte
    put_byte(8'h01, 1'b1);
    drain_results();

    // Random blocks at bias 3; hold the receiver off early so the result
    // queue fills and the input stalls.
    write_bias(2'd3);
    hold_req++;
    random_phase(300);
    drain_results();

    // Long runs at bias 2: saturate the match length, run a literal length
    // through a full extension byte and carry literals over zero matches.
    // Keep gaps short to bound the run time.
    write_bias(2'd2);
    long_gaps = 1'b0;
    buf_sequence(3, LEN_CAP + 3000, 16'h8001);
    ship_block(block_buf.size());
    buf_sequence(270, 0, 16'h0102);
    buf_sequence(1, 0, 16'h0304);
    buf_sequence(2, 5, 16'h0506);
    buf_tail(3);
    ship_block(block_buf.size());
    drain_results();
    long_gaps = 1'b1;
    random_phase(150);
    drain_results();

    // Biases below the usual range are taken as written.
    write_bias(2'd0);
    random_phase(90);
    drain_results();
    write_bias(2'd1);
    random_phase(90);
    drain_results();

    repeat (20) @(posedge clk);
    $display("run covered %0d byte transfers in %0d blocks and %0d results",
             byte_transfers, block_count, result_count);
    $display("biases 2, 3, 0 and 1; length caps, carried literals, cut blocks and noise");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
